/* sv/dimmer_light_controller_defines.svh */
// Assertion macros shared by the dimmer light controller checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef DIMMER_LIGHT_CONTROLLER_DEFINES_SVH
`define DIMMER_LIGHT_CONTROLLER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define DLC_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("dimmer light controller: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define DLC_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("dimmer light controller: same-cycle check failed");

`endif

/* sv/dlc_pkg.sv */
// Package of the dimmer light controller: codes, limits and beat types.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package dlc_pkg;

	localparam int LevelW = 8;
	localparam int ReqW   = 10;
	localparam int CmdW   = 3;
	localparam int ShutW  = 2;
	localparam int CfgIdxW = 1;
	localparam int CfgDataW = 8;

	localparam logic [LevelW-1:0] LevelMax = 8'hFF;
	localparam logic [ReqW-1:0]   ReqMax   = 10'd255;

	localparam logic [CmdW-1:0] CmdTick    = 3'd0;
	localparam logic [CmdW-1:0] CmdEncoder = 3'd1;
	localparam logic [CmdW-1:0] CmdButton  = 3'd2;
	localparam logic [CmdW-1:0] CmdOn      = 3'd3;
	localparam logic [CmdW-1:0] CmdOff     = 3'd4;
	localparam logic [CmdW-1:0] CmdSet     = 3'd5;
	localparam logic [CmdW-1:0] CmdShutter = 3'd6;
	localparam logic [CmdW-1:0] CmdOpen    = 3'd7;

	localparam logic [ShutW-1:0] ShutMoving = 2'd0;
	localparam logic [ShutW-1:0] ShutClosed = 2'd1;
	localparam logic [ShutW-1:0] ShutOpen   = 2'd2;

	localparam logic [CfgIdxW-1:0] CfgEncoderStep = 1'd0;
	localparam logic [CfgIdxW-1:0] CfgGate        = 1'd1;

	localparam logic [LevelW-1:0] StepReset = 8'd5;

	typedef struct packed {
		logic [CmdW-1:0]  command;
		logic             encoder_clock;
		logic             encoder_direction;
		logic             button_level;
		logic [ReqW-1:0]  level_value;
		logic [ShutW-1:0] shutter_state;
	} item_t;

	typedef struct packed {
		logic [LevelW-1:0] pwm_level;
		logic [LevelW-1:0] target_level;
		logic [LevelW-1:0] brightness_setting;
		logic              light_enabled;
		logic [ShutW-1:0]  shutter_status;
	} result_t;

endpackage

/* sv/dlc_core.sv */
// State and next-state logic of the dimmer light controller, plus its registers.
// Depends on dlc_pkg.
`timescale 1ns / 1ps

module dlc_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  dlc_pkg::item_t                item,
	input  logic                          cfg_we,
	input  logic [dlc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [dlc_pkg::CfgDataW-1:0]  cfg_data,
	output dlc_pkg::result_t              result
);

	logic [dlc_pkg::LevelW-1:0] step_q;
	logic                       gate_q;

	logic [dlc_pkg::LevelW-1:0] duty_q, target_q, bright_q;
	logic                       light_q, last_clock_q, last_button_q;
	logic [dlc_pkg::ShutW-1:0]  shut_now_q, shut_saved_q;

	logic [dlc_pkg::LevelW-1:0] duty_d, target_d, bright_d;
	logic                       light_d, last_clock_d, last_button_d;
	logic [dlc_pkg::ShutW-1:0]  shut_now_d, shut_saved_d;

	logic                       allowed;
	logic [dlc_pkg::LevelW:0]   up_sum;
	logic [dlc_pkg::LevelW-1:0] up_val, down_val, enc_val, set_val;

	always_comb begin
		allowed  = !gate_q || (shut_now_q == dlc_pkg::ShutClosed);
		up_sum   = {1'b0, bright_q} + {1'b0, step_q};
		up_val   = up_sum[dlc_pkg::LevelW] ? dlc_pkg::LevelMax : up_sum[dlc_pkg::LevelW-1:0];
		down_val = (bright_q > step_q) ? (bright_q - step_q) : '0;
		enc_val  = item.encoder_direction ? up_val : down_val;
		set_val  = (item.level_value > dlc_pkg::ReqMax) ? dlc_pkg::LevelMax
			: item.level_value[dlc_pkg::LevelW-1:0];

		duty_d        = duty_q;
		target_d      = target_q;
		bright_d      = bright_q;
		light_d       = light_q;
		last_clock_d  = last_clock_q;
		last_button_d = last_button_q;
		shut_now_d    = shut_now_q;
		shut_saved_d  = shut_saved_q;

		unique case (item.command)
			dlc_pkg::CmdTick: begin
				if (duty_q > target_q) begin
					duty_d = duty_q - 8'd1;
				end else if (duty_q < target_q) begin
					duty_d = duty_q + 8'd1;
				end
			end
			dlc_pkg::CmdEncoder: begin
				if (item.encoder_clock && !last_clock_q) begin
					bright_d = enc_val;
					target_d = (light_q && allowed) ? enc_val : '0;
				end
				last_clock_d = item.encoder_clock;
			end
			dlc_pkg::CmdButton: begin
				if (!item.button_level && last_button_q) begin
					light_d  = !light_q;
					target_d = (!light_q && allowed) ? bright_q : '0;
				end
				last_button_d = item.button_level;
			end
			dlc_pkg::CmdOn: begin
				light_d = 1'b1;
				if (allowed) begin
					target_d = bright_q;
				end
			end
			dlc_pkg::CmdOff: begin
				light_d  = 1'b0;
				target_d = '0;
			end
			dlc_pkg::CmdSet: begin
				bright_d = set_val;
				target_d = (light_q && allowed) ? set_val : '0;
			end
			dlc_pkg::CmdShutter: begin
				shut_now_d = item.shutter_state;
				if (item.shutter_state != dlc_pkg::ShutMoving
						&& item.shutter_state != shut_saved_q) begin
					if (item.shutter_state == dlc_pkg::ShutClosed) begin
						shut_saved_d = item.shutter_state;
						if (light_q) begin
							target_d = bright_q;
						end
					end else if (item.shutter_state == dlc_pkg::ShutOpen) begin
						shut_saved_d = item.shutter_state;
					end
				end
			end
			dlc_pkg::CmdOpen: begin
				if (gate_q) begin
					duty_d   = '0;
					target_d = '0;
				end
			end
		endcase

		result.pwm_level          = duty_d;
		result.target_level       = target_d;
		result.brightness_setting = bright_d;
		result.light_enabled      = light_d;
		result.shutter_status     = shut_now_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dlc_pkg::StepReset;
			gate_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dlc_pkg::CfgEncoderStep: step_q <= cfg_data;
				dlc_pkg::CfgGate:        gate_q <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q        <= '0;
			target_q      <= '0;
			bright_q      <= '0;
			light_q       <= 1'b0;
			last_clock_q  <= 1'b0;
			last_button_q <= 1'b0;
			shut_now_q    <= dlc_pkg::ShutClosed;
			shut_saved_q  <= dlc_pkg::ShutClosed;
		end else if (accept) begin
			duty_q        <= duty_d;
			target_q      <= target_d;
			bright_q      <= bright_d;
			light_q       <= light_d;
			last_clock_q  <= last_clock_d;
			last_button_q <= last_button_d;
			shut_now_q    <= shut_now_d;
			shut_saved_q  <= shut_saved_d;
		end
	end

endmodule

/* sv/dlc_outbuf.sv */
// Result register with a skid stage for the dimmer light controller.
// Depends on dlc_pkg.
`timescale 1ns / 1ps

module dlc_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dlc_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output dlc_pkg::result_t out_data
);

	logic             main_v_q, skid_v_q;
	dlc_pkg::result_t main_q, skid_q;
	logic             pop;

	assign pop       = main_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

/* sv/dimmer_light_controller.sv */
// Top level of the dimmer light controller: event channel, result channel, config port.
// Depends on dlc_pkg, dlc_core and dlc_outbuf.
//
//   channel  | handshake                  | beat contents
//   ---------+----------------------------+-------------------------------------------
//   event    | in_valid / in_stall        | command, encoder, button, level, shutter
//   result   | out_valid / out_stall      | pwm, target, brightness, light, shutter
//   config   | cfg_we                     | cfg_index, cfg_data
//
// Each event beat is processed combinationally; its result is registered in the result register, or in the skid entry.
// The state update and result register accept one event beat per cycle while in_stall is low.
// A result register plus one skid entry absorb a stalled result; in_stall shows that the skid entry is occupied.
// Reset clears all state but marks the shutter closed, loads encoder step 5 and gating on.
`timescale 1ns / 1ps

module dimmer_light_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dlc_pkg::CmdW-1:0]      command,
	input  logic                          encoder_clock,
	input  logic                          encoder_direction,
	input  logic                          button_level,
	input  logic [dlc_pkg::ReqW-1:0]      level_value,
	input  logic [dlc_pkg::ShutW-1:0]     shutter_state,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dlc_pkg::LevelW-1:0]    pwm_level,
	output logic [dlc_pkg::LevelW-1:0]    target_level,
	output logic [dlc_pkg::LevelW-1:0]    brightness_setting,
	output logic                          light_enabled,
	output logic [dlc_pkg::ShutW-1:0]     shutter_status,
	input  logic                          cfg_we,
	input  logic [dlc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [dlc_pkg::CfgDataW-1:0]  cfg_data
);

	dlc_pkg::item_t   item;
	dlc_pkg::result_t next_result, out_data;
	logic             accept, full;

	assign accept   = in_valid && !full;
	assign in_stall = full;

	always_comb begin
		item.command           = command;
		item.encoder_clock     = encoder_clock;
		item.encoder_direction = encoder_direction;
		item.button_level      = button_level;
		item.level_value       = level_value;
		item.shutter_state     = shutter_state;
	end

	dlc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (next_result)
	);

	dlc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (next_result),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign pwm_level          = out_data.pwm_level;
	assign target_level       = out_data.target_level;
	assign brightness_setting = out_data.brightness_setting;
	assign light_enabled      = out_data.light_enabled;
	assign shutter_status     = out_data.shutter_status;

endmodule

/* sv/dlc_checker.sv */
// Port-level checker for the dimmer light controller, bound to the top level.
// Depends on dlc_pkg and dimmer_light_controller_defines.svh.
`timescale 1ns / 1ps
`include "dimmer_light_controller_defines.svh"

module dlc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [dlc_pkg::CmdW-1:0]      command,
	input logic [dlc_pkg::ReqW-1:0]      level_value,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [dlc_pkg::LevelW-1:0]    pwm_level,
	input logic [dlc_pkg::LevelW-1:0]    target_level,
	input logic [dlc_pkg::LevelW-1:0]    brightness_setting,
	input logic                          light_enabled
);

	// A stalled result beat keeps its payload.
	`DLC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pwm_level) && $stable(target_level))

	// The skid entry can only be occupied behind a full result register.
	`DLC_ASSERT_NOW(a_skid_behind_main, clk, arst_n, in_stall, out_valid)

	// An off command into an empty buffer shows a dark target next cycle.
	`DLC_ASSERT_NEXT(a_off_clears, clk, arst_n, in_valid && !in_stall && !out_valid && command == dlc_pkg::CmdOff, out_valid && !light_enabled && target_level == '0)

	// A large set request into an empty buffer saturates the brightness.
	`DLC_ASSERT_NEXT(a_set_saturates, clk, arst_n, in_valid && !in_stall && !out_valid && command == dlc_pkg::CmdSet && level_value > dlc_pkg::ReqMax, out_valid && brightness_setting == dlc_pkg::LevelMax)

endmodule

bind dimmer_light_controller dlc_checker u_dlc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_stall           (in_stall),
	.command            (command),
	.level_value        (level_value),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.pwm_level          (pwm_level),
	.target_level       (target_level),
	.brightness_setting (brightness_setting),
	.light_enabled      (light_enabled)
);
